// ===== rtl/rtpg_pkg.sv =====
package rtpg_pkg;

   localparam int WORD_W    = 64;
   localparam int MAX_LANES = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 8;
   localparam int PCNT_W    = 2;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DISK_COUNT     = 2'd0,
      CSR_PARITY_COUNT   = 2'd1,
      CSR_REDUCTION_POLY = 2'd2,
      CSR_HALVING_CONST  = 2'd3
   } csr_index_type;

   typedef enum logic [PCNT_W-1:0] {
      PCNT_NONE = 2'd0,
      PCNT_P    = 2'd1,
      PCNT_PQ   = 2'd2,
      PCNT_PQR  = 2'd3
   } parity_count_type;

   typedef logic [MAX_LANES-1:0][7:0] lane_bytes_type;

   // per-lane next accumulator values
   typedef struct packed {
      lane_bytes_type p;
      lane_bytes_type q;
      lane_bytes_type r;
   } lane_result_type;

   // control from the column counter to the merge stage
   typedef struct packed {
      logic             push;
      logic             block_end;
      parity_count_type parity_count;
   } merge_ctrl_type;

   typedef struct packed {
      logic [WORD_W-1:0] p_word;
      logic [WORD_W-1:0] q_word;
      logic [WORD_W-1:0] r_word;
      logic              block_done;
   } rsp_payload_type;

endpackage

// ===== rtl/rtpg_req_if.sv =====
interface rtpg_req_if;
   import rtpg_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] data_word;
   logic              block_end;

   modport source (output valid, output data_word, output block_end, input ready);
   modport sink   (input valid, input data_word, input block_end, output ready);
endinterface

// ===== rtl/rtpg_rsp_if.sv =====
interface rtpg_rsp_if;
   import rtpg_pkg::*;

   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] p_word;
   logic [WORD_W-1:0] q_word;
   logic [WORD_W-1:0] r_word;
   logic              block_done;

   modport source (output valid, output p_word, output q_word, output r_word,
                   output block_done, input ready);
   modport sink   (input valid, input p_word, input q_word, input r_word,
                   input block_done, output ready);
endinterface

// ===== rtl/rtpg_lane.sv =====
module rtpg_lane (
   input  logic       clock,
   input  logic       enable,
   input  logic       start,
   input  logic [7:0] data_byte,
   input  logic [7:0] reduction_poly,
   input  logic [7:0] halving_const,
   output logic [7:0] p_next,
   output logic [7:0] q_next,
   output logic [7:0] r_next
);
   logic [7:0] p_ff, q_ff, r_ff;
   logic [7:0] p_in, q_in, r_in;
   logic [7:0] q_dbl, r_half;

   // gf(2^8) multiply by two and by its inverse
   assign q_dbl  = {q_ff[6:0], 1'b0} ^ (q_ff[7] ? reduction_poly : 8'h00);
   assign r_half = {1'b0, r_ff[7:1]} ^ (r_ff[0] ? halving_const : 8'h00);

   always_comb begin
      if (start) begin
         p_in = data_byte;
         q_in = data_byte;
         r_in = data_byte;
      end else begin
         p_in = p_ff ^ data_byte;
         q_in = q_dbl ^ data_byte;
         r_in = r_half ^ data_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         p_ff <= p_in;
         q_ff <= q_in;
         r_ff <= r_in;
      end
   end

   assign p_next = p_in;
   assign q_next = q_in;
   assign r_next = r_in;
endmodule

// ===== rtl/rtpg_merge.sv =====
module rtpg_merge #(
   parameter int BYTE_LANES = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  rtpg_pkg::lane_result_type lanes,
   input  rtpg_pkg::merge_ctrl_type  ctrl,
   output logic                      full,
   output logic                      out_valid,
   input  logic                      out_ready,
   output rtpg_pkg::rsp_payload_type out_data
);
   import rtpg_pkg::*;

   rsp_payload_type slot_ff [2];
   rsp_payload_type entry_in;
   logic            wr_ptr_ff, rd_ptr_ff;
   logic [1:0]      count_ff, count_in;
   logic            pop;
   lane_bytes_type  p_sel, q_sel, r_sel;

   // gather lane bytes, unused lanes read as zero
   always_comb begin
      p_sel = '0;
      q_sel = '0;
      r_sel = '0;
      for (int i = 0; i < BYTE_LANES; i++) begin
         p_sel[i] = lanes.p[i];
         q_sel[i] = lanes.q[i];
         r_sel[i] = lanes.r[i];
      end
      entry_in.p_word     = p_sel;
      entry_in.q_word     = (ctrl.parity_count == PCNT_PQ || ctrl.parity_count == PCNT_PQR)
                            ? q_sel : '0;
      entry_in.r_word     = (ctrl.parity_count == PCNT_PQR) ? r_sel : '0;
      entry_in.block_done = ctrl.block_end;
   end

   assign pop       = out_valid && out_ready;
   assign full      = count_ff[1];
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      case ({ctrl.push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         slot_ff[wr_ptr_ff] <= entry_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (ctrl.push) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      ctrl.push |-> (count_ff != 2'd2) || pop)
      else $error("result queue overflow");

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_ptr_track : assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd0 || count_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("result queue pointers out of step");
endmodule

// ===== rtl/raid_triple_parity_gen_top.sv =====
// raid triple parity generator: column-wise p/q/r parity over byte lanes in
// parallel. each req transaction carries one disk word; a column is disk_count
// words sent from the last data disk down to disk 0, and the word of disk 0
// produces one rsp transaction with p (xor), q (horner by 2 in gf(2^8)) and
// r (horner by 1/2), q and r zeroed according to parity_count. throughput is
// one word per clock while the result queue has room: each lane updates its
// accumulators with xor and shift logic; rsp valid rises in the cycle after
// the closing word is taken. a two-entry result queue lets words keep flowing
// while one result waits; req ready drops only when both queue entries are
// held. the user must write configuration through the csr port only while the
// block is idle (the block does not enforce this); a new disk_count is used from the next column on.
module raid_triple_parity_gen_top #(
   parameter int BYTE_LANES = 8
) (
   input  logic                           clock,
   input  logic                           reset,
   rtpg_req_if.sink                       req_chan,
   rtpg_rsp_if.source                     rsp_chan,
   input  logic                           csr_wr_en,
   input  logic [rtpg_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [rtpg_pkg::CSR_DAT_W-1:0] csr_wr_data
);
   import rtpg_pkg::*;

   // configuration registers
   logic [7:0]       disk_count_ff;
   parity_count_type parity_count_ff;
   logic [7:0]       reduction_poly_ff;
   logic [7:0]       halving_const_ff;

   // column control
   logic [7:0]       disks_left_ff, disks_left_in;
   logic             accept, start;
   logic [7:0]       col_len;
   logic             queue_full;

   lane_result_type  lanes;
   merge_ctrl_type   ctrl;
   rsp_payload_type  rsp_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         disk_count_ff     <= 8'd1;
         parity_count_ff   <= PCNT_PQR;
         reduction_poly_ff <= 8'd29;
         halving_const_ff  <= 8'd142;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_DISK_COUNT:     disk_count_ff     <= csr_wr_data;
            CSR_PARITY_COUNT:   parity_count_ff   <= parity_count_type'(csr_wr_data[PCNT_W-1:0]);
            CSR_REDUCTION_POLY: reduction_poly_ff <= csr_wr_data;
            CSR_HALVING_CONST:  halving_const_ff  <= csr_wr_data;
            default:            ;
         endcase
      end
   end

   // accept whenever the result queue has room
   assign req_chan.ready = !queue_full;
   assign accept         = req_chan.valid && !queue_full;

   // zero disk count behaves like a single disk
   assign col_len = (disk_count_ff == 8'd0) ? 8'd1 : disk_count_ff;
   assign start   = (disks_left_ff == 8'd0);

   always_comb begin
      disks_left_in = disks_left_ff;
      if (accept) begin
         disks_left_in = start ? (col_len - 8'd1) : (disks_left_ff - 8'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         disks_left_ff <= 8'd0;
      end else begin
         disks_left_ff <= disks_left_in;
      end
   end

   // one core per byte lane
   generate
      for (genvar i = 0; i < MAX_LANES; i++) begin : g_lane
         if (i < BYTE_LANES) begin : g_used
            rtpg_lane u_lane (
               .clock          (clock),
               .enable         (accept),
               .start          (start),
               .data_byte      (req_chan.data_word[8*i +: 8]),
               .reduction_poly (reduction_poly_ff),
               .halving_const  (halving_const_ff),
               .p_next         (lanes.p[i]),
               .q_next         (lanes.q[i]),
               .r_next         (lanes.r[i])
            );
         end else begin : g_unused
            assign lanes.p[i] = 8'h00;
            assign lanes.q[i] = 8'h00;
            assign lanes.r[i] = 8'h00;
         end
      end
   endgenerate

   // the word that brings the count to zero closes the column
   assign ctrl.push         = accept && (disks_left_in == 8'd0);
   assign ctrl.block_end    = req_chan.block_end;
   assign ctrl.parity_count = parity_count_ff;

   rtpg_merge #(
      .BYTE_LANES (BYTE_LANES)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .lanes     (lanes),
      .ctrl      (ctrl),
      .full      (queue_full),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_data  (rsp_data)
   );

   assign rsp_chan.p_word     = rsp_data.p_word;
   assign rsp_chan.q_word     = rsp_data.q_word;
   assign rsp_chan.r_word     = rsp_data.r_word;
   assign rsp_chan.block_done = rsp_data.block_done;

   // a word that opens a single-disk column always closes it
   a_single_close : assert property (@(posedge clock) disable iff (reset)
      (accept && start && disk_count_ff <= 8'd1) |-> ctrl.push)
      else $error("single disk column did not close");

   // a closed column leaves a pending result in the next cycle
   a_push_visible : assert property (@(posedge clock) disable iff (reset)
      ctrl.push |=> rsp_chan.valid)
      else $error("closed column produced no result");

   // mid-column words never produce a result
   a_mid_silent : assert property (@(posedge clock) disable iff (reset)
      (accept && disks_left_in != 8'd0) |-> !ctrl.push)
      else $error("result pushed inside a column");
endmodule
